### rtl/core/mra_pkg.sv
// ----------------------------------------------------------------------------
// mra_pkg
// Shared types and constants of the register ALU: command codes and widths.
// ----------------------------------------------------------------------------
package mra_pkg;

	localparam int unsigned DataW = 64;
	localparam int unsigned IdxW  = 5;
	localparam int unsigned CmdW  = 4;
	localparam int unsigned NumRegs = 1 << IdxW;

	typedef logic [DataW-1:0] data_t;
	typedef logic [IdxW-1:0]  idx_t;

	// Command codes; code 15 is unassigned and writes nothing
	typedef enum logic [CmdW-1:0] {
		CMD_ADD   = 4'd0,
		CMD_ADDU  = 4'd1,
		CMD_DADD  = 4'd2,
		CMD_DADDU = 4'd3,
		CMD_SUB   = 4'd4,
		CMD_SUBU  = 4'd5,
		CMD_DSUB  = 4'd6,
		CMD_DSUBU = 4'd7,
		CMD_AND   = 4'd8,
		CMD_OR    = 4'd9,
		CMD_XOR   = 4'd10,
		CMD_NOR   = 4'd11,
		CMD_SLT   = 4'd12,
		CMD_SLTU  = 4'd13,
		CMD_LOAD  = 4'd14
	} cmd_t;

	// ALU result with its status
	typedef struct packed {
		data_t result;
		logic  known;   // command is defined and produces a write value
	} alu_out_t;

endpackage

### rtl/core/mips64_register_alu_unit.sv
// ----------------------------------------------------------------------------
// mips64_register_alu_unit
// Three-register integer ALU over a 32 x 64-bit register file.
// ----------------------------------------------------------------------------
// One request per cycle is sustained while the output register can drain. The
// accepting edge reads both sources from the synchronous register file (two
// identical copies give the two read ports) into the execute stage; the execute
// stage computes, and the edge on which it fires writes back and loads the
// output register. A write in the same cycle as a dependent read is forwarded.
// Reset clears a valid bit per entry, so the file reads zero right after reset
// with no clearing pass. For an unassigned command the second read port fetches
// the destination so its unchanged content can be returned.
module mips64_register_alu_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [mra_pkg::CmdW-1:0] cmd,
	input  mra_pkg::idx_t            dest_index,
	input  mra_pkg::idx_t            src_a_index,
	input  mra_pkg::idx_t            src_b_index,
	input  mra_pkg::data_t           load_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output mra_pkg::data_t           dest_value,
	output logic                     wrote
);
	import mra_pkg::*;

	// Register file copies and per-entry valid bits
	data_t mem_a [NumRegs];
	data_t mem_b [NumRegs];
	logic [NumRegs-1:0] vld_q;

	// Stage 1 (execute) registers
	logic                valid_s1;
	logic [CmdW-1:0]     cmd_s1;
	idx_t                rd_s1;
	data_t               load_s1;
	data_t               rda_s1;
	data_t               rdb_s1;
	logic                a_zero_s1;
	logic                b_zero_s1;
	logic                a_byp_s1;
	logic                b_byp_s1;
	data_t               byp_val_s1;

	// Output register
	logic  out_valid_q;
	data_t dest_value_q;
	logic  wrote_q;

	logic     accept;
	logic     s1_fire;
	logic     wen;
	idx_t     rb_addr;
	data_t    opa;
	data_t    opb;
	alu_out_t alu_res;

	// Handshake and stage advance
	assign s1_fire  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_fire;
	assign accept   = in_valid && in_ready;
	assign wen      = s1_fire && alu_res.known && (rd_s1 != '0);

	// Undefined command reads the destination through port B
	assign rb_addr = (cmd > CMD_LOAD) ? dest_index : src_b_index;

	// Memory copy for source A
	always_ff @(posedge clk) begin
		if (wen) begin
			mem_a[rd_s1] <= alu_res.result;
		end
		if (accept) begin
			rda_s1 <= mem_a[src_a_index];
		end
	end

	// Memory copy for source B / destination readback
	always_ff @(posedge clk) begin
		if (wen) begin
			mem_b[rd_s1] <= alu_res.result;
		end
		if (accept) begin
			rdb_s1 <= mem_b[rb_addr];
		end
	end

	// Valid bits: an entry never written reads zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wen) begin
			vld_q[rd_s1] <= 1'b1;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload, zero flags and forwarding from the write in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= cmd;
			rd_s1      <= dest_index;
			load_s1    <= load_value;
			a_zero_s1  <= (src_a_index == '0) || !vld_q[src_a_index];
			b_zero_s1  <= (rb_addr == '0) || !vld_q[rb_addr];
			a_byp_s1   <= wen && (rd_s1 == src_a_index);
			b_byp_s1   <= wen && (rd_s1 == rb_addr);
			byp_val_s1 <= alu_res.result;
		end
	end

	// Operand select
	always_comb begin
		priority if (a_byp_s1) opa = byp_val_s1;
		else if (a_zero_s1)    opa = '0;
		else                   opa = rda_s1;
		priority if (b_byp_s1) opb = byp_val_s1;
		else if (b_zero_s1)    opb = '0;
		else                   opb = rdb_s1;
	end

	mra_alu u_alu (
		.cmd        (cmd_s1),
		.opa        (opa),
		.opb        (opb),
		.load_value (load_s1),
		.res        (alu_res)
	);

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: zero for entry 0, old content for unassigned command
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			wrote_q <= wen;
			priority if (rd_s1 == '0) dest_value_q <= '0;
			else if (alu_res.known)   dest_value_q <= alu_res.result;
			else                      dest_value_q <= opb;
		end
	end

	assign out_valid  = out_valid_q;
	assign dest_value = dest_value_q;
	assign wrote      = wrote_q;

`ifndef SYNTHESIS
	// Entry 0 is never marked written
	a_no_zero_write: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[0])
		else $error("register 0 marked written");

	// A write-back leaves its entry valid
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wen |=> vld_q[$past(rd_s1)])
		else $error("written entry not valid");

	// Each execute completion fills the output register
	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> out_valid_q && (wrote_q == $past(wen)))
		else $error("execute result lost");
`endif

endmodule

### rtl/core/mra_alu.sv
// ----------------------------------------------------------------------------
// mra_alu
// Combinational integer datapath: add/sub (32 and 64 bit), logic, set-less-than
// and load pass-through.
// ----------------------------------------------------------------------------
module mra_alu (
	input  logic [mra_pkg::CmdW-1:0] cmd,
	input  mra_pkg::data_t           opa,
	input  mra_pkg::data_t           opb,
	input  mra_pkg::data_t           load_value,
	output mra_pkg::alu_out_t        res
);
	import mra_pkg::*;

	data_t sum;
	data_t diff;

	assign sum  = opa + opb;
	assign diff = opa - opb;

	// Operation select; 32-bit forms sign-extend their low word
	always_comb begin
		res.result = '0;
		res.known  = 1'b1;
		unique case (cmd)
			CMD_ADD, CMD_ADDU:   res.result = {{32{sum[31]}}, sum[31:0]};
			CMD_DADD, CMD_DADDU: res.result = sum;
			CMD_SUB, CMD_SUBU:   res.result = {{32{diff[31]}}, diff[31:0]};
			CMD_DSUB, CMD_DSUBU: res.result = diff;
			CMD_AND:             res.result = opa & opb;
			CMD_OR:              res.result = opa | opb;
			CMD_XOR:             res.result = opa ^ opb;
			CMD_NOR:             res.result = ~(opa | opb);
			CMD_SLT:             res.result = {{(DataW-1){1'b0}}, $signed(opa) < $signed(opb)};
			CMD_SLTU:            res.result = {{(DataW-1){1'b0}}, opa < opb};
			CMD_LOAD:            res.result = load_value;
			default:             res.known  = 1'b0;
		endcase
	end

endmodule

### tb/sv/mra_writeback_checker.sv
// ----------------------------------------------------------------------------
// mra_writeback_checker
// Watches both channels of the register ALU. It keeps a shadow register file,
// works out the write-back of every accepted request and compares each result
// with the oldest expected one.
// ----------------------------------------------------------------------------
module mra_writeback_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [mra_pkg::CmdW-1:0] cmd,
	input  mra_pkg::idx_t            dest_index,
	input  mra_pkg::idx_t            src_a_index,
	input  mra_pkg::idx_t            src_b_index,
	input  mra_pkg::data_t           load_value,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  mra_pkg::data_t           dest_value,
	input  logic                     wrote,
	output int                       fail_count,
	output int                       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import mra_pkg::*;

	typedef struct packed {
		data_t value;
		logic  wrote;
	} writeback_t;

	data_t      shadow_gpr [NumRegs];
	writeback_t expected_writebacks [$];
	int         errors;

	// Read a shadow register; entry 0 is hard-wired to zero
	function automatic data_t read_gpr(idx_t idx);
		return (idx == '0) ? '0 : shadow_gpr[idx];
	endfunction

	// Execute one request against the shadow file and return its write-back
	function automatic writeback_t execute_request(logic [CmdW-1:0] op, idx_t rd, idx_t ra,
			idx_t rb, data_t ld);
		data_t      a;
		data_t      b;
		data_t      r;
		logic [31:0] w;
		logic       known;
		writeback_t res;
		// both sources are read before any write
		a = read_gpr(ra);
		b = read_gpr(rb);
		r = '0;
		w = '0;
		known = 1'b1;
		case (op)
			CMD_ADD, CMD_ADDU: begin
				w = a[31:0] + b[31:0];
				r = {{32{w[31]}}, w};
			end
			CMD_SUB, CMD_SUBU: begin
				w = a[31:0] - b[31:0];
				r = {{32{w[31]}}, w};
			end
			CMD_DADD, CMD_DADDU: r = a + b;
			CMD_DSUB, CMD_DSUBU: r = a - b;
			CMD_AND:  r = a & b;
			CMD_OR:   r = a | b;
			CMD_XOR:  r = a ^ b;
			CMD_NOR:  r = ~(a | b);
			CMD_SLT:  r = ($signed(a) < $signed(b)) ? data_t'(1) : '0;
			CMD_SLTU: r = (a < b) ? data_t'(1) : '0;
			CMD_LOAD: r = ld;
			default:  known = 1'b0;   // unassigned code writes nothing
		endcase
		if (known && rd != '0)
			shadow_gpr[rd] = r;
		res.wrote = known && (rd != '0);
		res.value = read_gpr(rd);
		return res;
	endfunction

	// Track requests and results on every edge
	always @(posedge clk or negedge arst_n) begin
		writeback_t exp_wb;
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++)
				shadow_gpr[i] = '0;
			expected_writebacks.delete();
			errors = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// result side: compare against the oldest write-back
			if (out_valid && out_ready) begin
				if (expected_writebacks.size() == 0) begin
					errors++;
					$display("%0t: unexpected result dest_value=%h wrote=%b",
						$time, dest_value, wrote);
				end else begin
					exp_wb = expected_writebacks.pop_front();
					if (dest_value !== exp_wb.value) begin
						errors++;
						$display("%0t: dest_value expected %h actual %h",
							$time, exp_wb.value, dest_value);
					end
					if (wrote !== exp_wb.wrote) begin
						errors++;
						$display("%0t: wrote expected %b actual %b",
							$time, exp_wb.wrote, wrote);
					end
				end
			end
			// request side: predict the write-back
			if (in_valid && in_ready)
				expected_writebacks.push_back(execute_request(cmd, dest_index,
					src_a_index, src_b_index, load_value));
			fail_count <= errors;
			outstanding <= expected_writebacks.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives requests into the register ALU: a directed set over operand extremes,
// every command and the register-zero and unassigned-command cases, then
// random requests in bursts while the result side stalls. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mra_pkg::*;

	localparam logic [CmdW-1:0] CMD_UNASSIGNED = 4'hF;
	localparam int RandomRequests = 800;
	localparam int IdleLimit = 4000;
	localparam int LongHoldCycles = 200;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [CmdW-1:0] cmd;
	idx_t            dest_index;
	idx_t            src_a_index;
	idx_t            src_b_index;
	data_t           load_value;
	logic            out_valid;
	logic            out_ready;
	data_t           dest_value;
	logic            wrote;
	int              fail_count;
	int              outstanding;

	bit              rx_hold_go = 1'b0;
	int              burst_left = 0;
	int              idle_cycles = 0;

	mips64_register_alu_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.dest_index  (dest_index),
		.src_a_index (src_a_index),
		.src_b_index (src_b_index),
		.load_value  (load_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dest_value  (dest_value),
		.wrote       (wrote)
	);

	mra_writeback_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.dest_index  (dest_index),
		.src_a_index (src_a_index),
		.src_b_index (src_b_index),
		.load_value  (load_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dest_value  (dest_value),
		.wrote       (wrote),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Offer one request and hold it until taken, then maybe open a gap
	task automatic send_request(logic [CmdW-1:0] op, idx_t rd, idx_t ra, idx_t rb, data_t ld);
		in_valid    <= 1'b1;
		cmd         <= op;
		dest_index  <= rd;
		src_a_index <= ra;
		src_b_index <= rb;
		load_value  <= ld;
		do
			@(posedge clk);
		while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			// every so often a long gapless stretch
			burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(0, 30);
		end
	endtask

	// Stop offering and wait until every result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Load values biased toward sign and carry boundaries
	function automatic data_t pick_value();
		case ($urandom_range(0, 7))
			0: return 64'h7FFF_FFFF_FFFF_FFFF;
			1: return 64'h8000_0000_0000_0000;
			2: return '1;
			3: return {32'h0, 1'b0, {31{1'b1}}} | data_t'($urandom_range(0, 1) << 31);
			4: return data_t'($urandom_range(0, 3));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Random request: a working set of low registers keeps results dependent
	task automatic send_random_request();
		logic [CmdW-1:0] op;
		idx_t            rd;
		idx_t            ra;
		idx_t            rb;
		int              pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			op = CMD_LOAD;
		else if (pick < 28)
			op = CMD_UNASSIGNED;
		else
			op = CmdW'($urandom_range(CMD_ADD, CMD_SLTU));
		rd = ($urandom_range(0, 3) == 0) ? idx_t'($urandom) : idx_t'($urandom_range(0, 7));
		ra = ($urandom_range(0, 3) == 0) ? idx_t'($urandom) : idx_t'($urandom_range(0, 7));
		rb = ($urandom_range(0, 3) == 0) ? idx_t'($urandom) : idx_t'($urandom_range(0, 7));
		send_request(op, rd, ra, rb, pick_value());
	endtask

	// Result side: stall patterns picked at random in turn, plus one long hold
	initial begin
		int rx_mode;
		int rx_cycle;
		rx_mode = 0;
		rx_cycle = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_go) begin
				out_ready <= 1'b0;
				repeat (LongHoldCycles) @(posedge clk);
				rx_hold_go = 1'b0;
			end else begin
				if (rx_cycle % 64 == 0)
					rx_mode = $urandom_range(0, 3);
				rx_cycle++;
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (rx_cycle % 8) < 5;
				endcase
			end
		end
	end

	// Watchdog: too long without any handshake ends the run
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("mips64_register_alu_unit: mismatch");
			$finish;
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		cmd         <= CMD_ADD;
		dest_index  <= '0;
		src_a_index <= '0;
		src_b_index <= '0;
		load_value  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// operand extremes into the file; a load to register zero is dropped
		send_request(CMD_LOAD, 5'd1, 5'd0, 5'd0, 64'h7FFF_FFFF_FFFF_FFFF);
		send_request(CMD_LOAD, 5'd2, 5'd0, 5'd0, 64'h8000_0000_0000_0000);
		send_request(CMD_LOAD, 5'd3, 5'd0, 5'd0, '1);
		send_request(CMD_LOAD, 5'd4, 5'd0, 5'd0, 64'h0000_0000_7FFF_FFFF);
		send_request(CMD_LOAD, 5'd5, 5'd0, 5'd0, 64'h1);
		send_request(CMD_LOAD, 5'd0, 5'd0, 5'd0, '1);
		// 32-bit forms overflow into the sign; 64-bit forms wrap
		send_request(CMD_ADD,   5'd6,  5'd4, 5'd5, '0);
		send_request(CMD_ADDU,  5'd7,  5'd3, 5'd5, '0);
		send_request(CMD_DADD,  5'd8,  5'd1, 5'd5, '0);
		send_request(CMD_DADDU, 5'd9,  5'd3, 5'd3, '0);
		send_request(CMD_SUB,   5'd10, 5'd0, 5'd5, '0);
		send_request(CMD_SUBU,  5'd11, 5'd2, 5'd5, '0);
		send_request(CMD_DSUB,  5'd12, 5'd2, 5'd5, '0);
		send_request(CMD_DSUBU, 5'd13, 5'd0, 5'd3, '0);
		// logic and compares
		send_request(CMD_AND,  5'd14, 5'd3, 5'd1, '0);
		send_request(CMD_OR,   5'd15, 5'd2, 5'd5, '0);
		send_request(CMD_XOR,  5'd16, 5'd3, 5'd1, '0);
		send_request(CMD_NOR,  5'd17, 5'd0, 5'd0, '0);
		send_request(CMD_SLT,  5'd18, 5'd2, 5'd1, '0);
		send_request(CMD_SLTU, 5'd19, 5'd2, 5'd1, '0);
		send_request(CMD_SLT,  5'd20, 5'd3, 5'd0, '0);
		// destination zero, unassigned code, destination equal to a source
		send_request(CMD_SUB, 5'd0, 5'd1, 5'd2, '0);
		send_request(CMD_UNASSIGNED, 5'd3, 5'd1, 5'd2, '1);
		send_request(CMD_DADD, 5'd5, 5'd5, 5'd5, '0);
		send_request(CMD_LOAD, 5'd31, 5'd31, 5'd31, 64'h5555_5555_AAAA_AAAA);
		drain_results();

		// random part; the result side holds off early while requests keep coming
		rx_hold_go = 1'b1;
		burst_left = 300;
		for (int n = 0; n < RandomRequests; n++) begin
			send_random_request();
			if (n == RandomRequests / 2)
				drain_results();
		end
		drain_results();
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("mips64_register_alu_unit: match");
		else
			$display("mips64_register_alu_unit: mismatch");
		$finish;
	end

endmodule
